// File: rtl/tgal_pkg.sv
package tgal_pkg;

    typedef enum logic [1:0] {
        PH_STOPPED = 2'd0,
        PH_HEADER  = 2'd1,
        PH_IDSKIP  = 2'd2,
        PH_PIXELS  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        RK_PIXEL  = 2'd0,
        RK_HEADER = 2'd1,
        RK_ERROR  = 2'd2
    } result_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_COLORMAP   = 3'd1,
        ERR_IMAGE_TYPE = 3'd2,
        ERR_BPP        = 3'd3,
        ERR_ALPHA      = 3'd4
    } error_code_t;

    localparam logic [4:0] HDR_ID_LENGTH      = 5'd0;
    localparam logic [4:0] HDR_CMAP_TYPE      = 5'd1;
    localparam logic [4:0] HDR_IMAGE_TYPE     = 5'd2;
    localparam logic [4:0] HDR_CMAP_SPEC_FIRST = 5'd3;
    localparam logic [4:0] HDR_CMAP_SPEC_LAST = 5'd7;
    localparam logic [4:0] HDR_WIDTH_LO       = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI       = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO      = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI      = 5'd15;
    localparam logic [4:0] HDR_BPP            = 5'd16;
    localparam logic [4:0] HDR_DESCRIPTOR     = 5'd17;

    localparam logic [7:0] CMAP_NONE       = 8'h00;
    localparam logic [7:0] TYPE_TRUECOLOR  = 8'h02;
    localparam logic [7:0] BPP_32          = 8'h20;
    localparam logic [3:0] ALPHA_BITS_8    = 4'd8;

    localparam logic [1:0] LANE_ALPHA      = 2'd3;

    localparam logic CFG_MIRROR_INDEX = 1'b0;

    typedef struct packed {
        result_kind_t kind;
        error_code_t  err;
        logic [15:0]  width;
        logic [15:0]  height;
        logic [15:0]  column;
        logic [15:0]  row;
        logic         flip_col;
        logic         flip_row;
        logic [7:0]   red;
        logic [7:0]   green;
        logic [7:0]   blue;
        logic [7:0]   alpha;
        logic         last;
    } cmd_t;

    typedef struct packed {
        result_kind_t kind;
        error_code_t  err;
        logic [15:0]  image_width;
        logic [15:0]  image_height;
        logic [15:0]  pixel_column;
        logic [15:0]  pixel_row;
        logic [7:0]   red;
        logic [7:0]   green;
        logic [7:0]   blue;
        logic [7:0]   alpha;
        logic         last;
    } result_t;

endpackage

// File: rtl/tga_uncompressed_rgba_loader.sv
// Streaming decoder for 32-bit truecolor TGA files, one file byte per transfer
// on the s_ side with s_tuser marking the first byte of a file. It takes one
// byte every cycle unless the queue is full and gives at most one result per
// byte: a header-accepted result after header byte 17, one error result on the
// first failed header check, and one pixel result on every fourth pixel byte,
// with column and row already mirrored. The parser front end hands results to
// a two-entry queue and the formatting back end registers them on the m_ side,
// so a result passes a queue slot and then the output register. s_tready drops
// only when the queue is full behind a stalled output. mirror_mode is written
// at APB addresses 0-3 and takes effect at the next header's descriptor byte.
module tga_uncompressed_rgba_loader (
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,

    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] file_byte
    input  logic          s_tuser,   // [0] start_of_file

    output logic          m_tvalid,
    input  logic          m_tready,
    // [2:0] error_code, [18:3] image_width, [34:19] image_height,
    // [50:35] pixel_column, [66:51] pixel_row, [74:67] red, [82:75] green,
    // [90:83] blue, [98:91] alpha, [103:99] zero
    output logic [103:0]  m_tdata,
    output logic [1:0]    m_tuser,   // [1:0] result_kind
    output logic          m_tlast    // last_pixel
);

    logic [1:0]        mirror_reg, mirror_next;
    logic              cfg_write;
    logic              in_accept;
    logic              push;
    tgal_pkg::cmd_t    push_cmd;
    logic              q_full;
    logic              pop;
    logic              head_valid;
    tgal_pkg::cmd_t    head_cmd;
    tgal_pkg::result_t out_result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == tgal_pkg::CFG_MIRROR_INDEX);
    assign prdata    = (paddr[2] == tgal_pkg::CFG_MIRROR_INDEX)
                       ? {30'd0, mirror_reg} : 32'd0;

    always_comb begin
        mirror_next = cfg_write ? pwdata[1:0] : mirror_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mirror_reg <= 2'd0;
        end else begin
            mirror_reg <= mirror_next;
        end
    end

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    tgal_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .in_byte     (s_tdata),
        .in_start    (s_tuser),
        .mirror_mode (mirror_reg),
        .push        (push),
        .cmd         (push_cmd)
    );

    tgal_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    tgal_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {5'd0, out_result.alpha, out_result.blue, out_result.green,
                      out_result.red, out_result.pixel_row, out_result.pixel_column,
                      out_result.image_height, out_result.image_width, out_result.err};
    assign m_tuser = out_result.kind;
    assign m_tlast = out_result.last;

    a_last_is_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> out_result.kind == tgal_pkg::RK_PIXEL)
        else $error("last flag on a non-pixel result");

    a_error_has_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_result.kind == tgal_pkg::RK_ERROR
        |-> out_result.err != tgal_pkg::ERR_NONE)
        else $error("error result without an error code");

    a_size_only_on_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_result.kind != tgal_pkg::RK_HEADER
        |-> out_result.image_width == 16'd0 && out_result.image_height == 16'd0)
        else $error("image size on a result other than header accepted");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("front end pushed into a full queue");

endmodule

// File: rtl/tgal_front.sv
module tgal_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_accept,
    input  logic [7:0]         in_byte,
    input  logic               in_start,
    input  logic [1:0]         mirror_mode,
    output logic               push,
    output tgal_pkg::cmd_t     cmd
);

    tgal_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [7:0]  id_left_reg, id_left_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic        flip_col_reg, flip_col_next;
    logic        flip_row_reg, flip_row_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [1:0]  lane_reg, lane_next;
    logic [23:0] held_reg, held_next;

    tgal_pkg::phase_t      eff_phase;
    logic [4:0]            eff_pos;
    logic [7:0]            eff_id_left;
    logic [15:0]           eff_width;
    logic [15:0]           eff_height;
    logic [15:0]           eff_col;
    logic [15:0]           eff_row;
    logic [1:0]            eff_lane;
    logic [23:0]           eff_held;
    logic                  hdr_fail;
    tgal_pkg::error_code_t fail_code;
    logic                  hdr_end;
    logic                  pix_emit;
    logic                  last_col;
    logic                  last_row;

    // classify the byte against the state it sees after a possible restart
    always_comb begin
        eff_phase   = in_start ? tgal_pkg::PH_HEADER : phase_reg;
        eff_pos     = in_start ? 5'd0 : pos_reg;
        eff_id_left = in_start ? 8'd0 : id_left_reg;
        eff_width   = in_start ? 16'd0 : width_reg;
        eff_height  = in_start ? 16'd0 : height_reg;
        eff_col     = in_start ? 16'd0 : col_reg;
        eff_row     = in_start ? 16'd0 : row_reg;
        eff_lane    = in_start ? 2'd0 : lane_reg;
        eff_held    = in_start ? 24'd0 : held_reg;

        hdr_fail  = 1'b0;
        fail_code = tgal_pkg::ERR_NONE;
        case (eff_pos) inside
            tgal_pkg::HDR_CMAP_TYPE: begin
                if (in_byte != tgal_pkg::CMAP_NONE) begin
                    hdr_fail  = 1'b1;
                    fail_code = tgal_pkg::ERR_COLORMAP;
                end
            end
            tgal_pkg::HDR_IMAGE_TYPE: begin
                if (in_byte != tgal_pkg::TYPE_TRUECOLOR) begin
                    hdr_fail  = 1'b1;
                    fail_code = tgal_pkg::ERR_IMAGE_TYPE;
                end
            end
            [tgal_pkg::HDR_CMAP_SPEC_FIRST:tgal_pkg::HDR_CMAP_SPEC_LAST]: begin
                if (in_byte != tgal_pkg::CMAP_NONE) begin
                    hdr_fail  = 1'b1;
                    fail_code = tgal_pkg::ERR_COLORMAP;
                end
            end
            tgal_pkg::HDR_BPP: begin
                if (in_byte != tgal_pkg::BPP_32) begin
                    hdr_fail  = 1'b1;
                    fail_code = tgal_pkg::ERR_BPP;
                end
            end
            tgal_pkg::HDR_DESCRIPTOR: begin
                if (in_byte[3:0] != tgal_pkg::ALPHA_BITS_8) begin
                    hdr_fail  = 1'b1;
                    fail_code = tgal_pkg::ERR_ALPHA;
                end
            end
            default: begin
            end
        endcase
        hdr_end = (eff_pos == tgal_pkg::HDR_DESCRIPTOR) && !hdr_fail;

        pix_emit = (eff_lane == tgal_pkg::LANE_ALPHA);
        last_col = ({1'b0, eff_col} + 17'd1) >= {1'b0, eff_width};
        last_row = ({1'b0, eff_row} + 17'd1) >= {1'b0, eff_height};
    end

    always_comb begin
        phase_next = phase_reg;
        if (in_accept) begin
            unique case (eff_phase)
                tgal_pkg::PH_STOPPED: begin
                    phase_next = tgal_pkg::PH_STOPPED;
                end
                tgal_pkg::PH_HEADER: begin
                    if (hdr_fail) begin
                        phase_next = tgal_pkg::PH_STOPPED;
                    end else if (hdr_end) begin
                        if (eff_width == 16'd0 || eff_height == 16'd0) begin
                            phase_next = tgal_pkg::PH_STOPPED;
                        end else if (eff_id_left != 8'd0) begin
                            phase_next = tgal_pkg::PH_IDSKIP;
                        end else begin
                            phase_next = tgal_pkg::PH_PIXELS;
                        end
                    end else begin
                        phase_next = tgal_pkg::PH_HEADER;
                    end
                end
                tgal_pkg::PH_IDSKIP: begin
                    phase_next = (eff_id_left == 8'd1) ? tgal_pkg::PH_PIXELS
                                                       : tgal_pkg::PH_IDSKIP;
                end
                tgal_pkg::PH_PIXELS: begin
                    phase_next = (pix_emit && last_col && last_row) ? tgal_pkg::PH_STOPPED
                                                                    : tgal_pkg::PH_PIXELS;
                end
            endcase
        end
    end

    always_comb begin
        pos_next      = pos_reg;
        id_left_next  = id_left_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        flip_col_next = flip_col_reg;
        flip_row_next = flip_row_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        lane_next     = lane_reg;
        held_next     = held_reg;
        if (in_accept) begin
            pos_next     = eff_pos;
            id_left_next = eff_id_left;
            width_next   = eff_width;
            height_next  = eff_height;
            col_next     = eff_col;
            row_next     = eff_row;
            lane_next    = eff_lane;
            held_next    = eff_held;
            case (eff_phase)
                tgal_pkg::PH_HEADER: begin
                    pos_next = eff_pos + 5'd1;
                    case (eff_pos)
                        tgal_pkg::HDR_ID_LENGTH:  id_left_next      = in_byte;
                        tgal_pkg::HDR_WIDTH_LO:   width_next[7:0]   = in_byte;
                        tgal_pkg::HDR_WIDTH_HI:   width_next[15:8]  = in_byte;
                        tgal_pkg::HDR_HEIGHT_LO:  height_next[7:0]  = in_byte;
                        tgal_pkg::HDR_HEIGHT_HI:  height_next[15:8] = in_byte;
                        default: begin
                        end
                    endcase
                    if (hdr_end) begin
                        flip_col_next = in_byte[4] ^ mirror_mode[0];
                        flip_row_next = ~(in_byte[5] ^ mirror_mode[1]);
                        col_next      = 16'd0;
                        row_next      = 16'd0;
                        lane_next     = 2'd0;
                        held_next     = 24'd0;
                    end
                end
                tgal_pkg::PH_IDSKIP: begin
                    id_left_next = eff_id_left - 8'd1;
                end
                tgal_pkg::PH_PIXELS: begin
                    if (!pix_emit) begin
                        case (eff_lane)
                            2'd0:    held_next[7:0]   = in_byte;
                            2'd1:    held_next[15:8]  = in_byte;
                            default: held_next[23:16] = in_byte;
                        endcase
                        lane_next = eff_lane + 2'd1;
                    end else begin
                        lane_next = 2'd0;
                        held_next = 24'd0;
                        if (last_col) begin
                            col_next = 16'd0;
                            if (!last_row) begin
                                row_next = eff_row + 16'd1;
                            end
                        end else begin
                            col_next = eff_col + 16'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        push          = 1'b0;
        cmd           = '0;
        cmd.kind      = tgal_pkg::RK_PIXEL;
        cmd.err       = tgal_pkg::ERR_NONE;
        cmd.width     = eff_width;
        cmd.height    = eff_height;
        cmd.column    = eff_col;
        cmd.row       = eff_row;
        cmd.flip_col  = flip_col_reg;
        cmd.flip_row  = flip_row_reg;
        cmd.red       = eff_held[23:16];
        cmd.green     = eff_held[15:8];
        cmd.blue      = eff_held[7:0];
        cmd.alpha     = in_byte;
        cmd.last      = last_col && last_row;
        if (in_accept) begin
            if (eff_phase == tgal_pkg::PH_HEADER && hdr_fail) begin
                push     = 1'b1;
                cmd.kind = tgal_pkg::RK_ERROR;
                cmd.err  = fail_code;
            end else if (eff_phase == tgal_pkg::PH_HEADER && hdr_end) begin
                push     = 1'b1;
                cmd.kind = tgal_pkg::RK_HEADER;
            end else if (eff_phase == tgal_pkg::PH_PIXELS && pix_emit) begin
                push     = 1'b1;
                cmd.kind = tgal_pkg::RK_PIXEL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= tgal_pkg::PH_STOPPED;
            pos_reg      <= 5'd0;
            id_left_reg  <= 8'd0;
            width_reg    <= 16'd0;
            height_reg   <= 16'd0;
            flip_col_reg <= 1'b0;
            flip_row_reg <= 1'b0;
            col_reg      <= 16'd0;
            row_reg      <= 16'd0;
            lane_reg     <= 2'd0;
            held_reg     <= 24'd0;
        end else begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            id_left_reg  <= id_left_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            flip_col_reg <= flip_col_next;
            flip_row_reg <= flip_row_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            lane_reg     <= lane_next;
            held_reg     <= held_next;
        end
    end

endmodule

// File: rtl/tgal_queue.sv
module tgal_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tgal_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output tgal_pkg::cmd_t head_cmd
);

    tgal_pkg::cmd_t slots [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = slots[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/tgal_back.sv
module tgal_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  tgal_pkg::cmd_t    head_cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output tgal_pkg::result_t out_result
);

    logic              valid_reg, valid_next;
    tgal_pkg::result_t result_reg;
    tgal_pkg::result_t formatted;

    assign pop        = head_valid && (!valid_reg || out_ready);
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb begin
        formatted      = '0;
        formatted.kind = head_cmd.kind;
        formatted.err  = tgal_pkg::ERR_NONE;
        case (head_cmd.kind)
            tgal_pkg::RK_PIXEL: begin
                formatted.pixel_column = head_cmd.flip_col
                    ? head_cmd.width - 16'd1 - head_cmd.column : head_cmd.column;
                formatted.pixel_row = head_cmd.flip_row
                    ? head_cmd.height - 16'd1 - head_cmd.row : head_cmd.row;
                formatted.red   = head_cmd.red;
                formatted.green = head_cmd.green;
                formatted.blue  = head_cmd.blue;
                formatted.alpha = head_cmd.alpha;
                formatted.last  = head_cmd.last;
            end
            tgal_pkg::RK_HEADER: begin
                formatted.image_width  = head_cmd.width;
                formatted.image_height = head_cmd.height;
            end
            tgal_pkg::RK_ERROR: begin
                formatted.err = head_cmd.err;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            result_reg <= formatted;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule
